@@ rtl/vtp_pkg.sv @@
// types, constants and the configuration-derived parameter table for the vrb to prb mapper
`default_nettype none

package vtp_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_SEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd2;

  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [6:0] BANDWIDTH_RESET = 7'd50;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_GAP   = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;

  // remainder unit: two restoring steps per stage, eight quotient bits
  localparam int unsigned DIV_STAGES = 4;

  // parameters that follow from the configuration registers
  typedef struct packed {
    logic [6:0] rbs;
    logic       mode;
    logic       gap_err;
    logic [5:0] ngap;
    logic [6:0] ndl;
    logic [6:0] ntil;
    logic [5:0] half;
    logic [4:0] nrow;
    logic [4:0] nnull;
    logic [6:0] divisor;
  } vtp_drv_t;

  // one item in flight through the remainder stages
  typedef struct packed {
    logic [7:0]  nvrb;
    logic [7:0]  rem;
    logic [13:0] dsh;
    logic        odd;
    logic        last;
    logic [1:0]  status;
  } vtp_item_t;

  function automatic vtp_drv_t vtp_derive(input logic [6:0] rbs, input logic sel,
                                          input logic mode);
    vtp_drv_t   r;
    logic [5:0] ngap;
    logic [6:0] rest;
    logic [6:0] m;
    logic [6:0] ndl;
    logic [6:0] ntil;
    logic [2:0] p;
    logic [7:0] kq;

    // gap table, zero where the gap is not defined
    ngap = 6'd0;
    if (rbs >= 7'd6 && rbs <= 7'd10) ngap = sel ? 6'd0 : 6'((rbs + 7'd1) >> 1);
    else if (rbs == 7'd11) ngap = sel ? 6'd0 : 6'd4;
    else if (rbs >= 7'd12 && rbs <= 7'd19) ngap = sel ? 6'd0 : 6'd8;
    else if (rbs >= 7'd20 && rbs <= 7'd26) ngap = sel ? 6'd0 : 6'd12;
    else if (rbs >= 7'd27 && rbs <= 7'd44) ngap = sel ? 6'd0 : 6'd18;
    else if (rbs >= 7'd45 && rbs <= 7'd49) ngap = sel ? 6'd0 : 6'd27;
    else if (rbs >= 7'd50 && rbs <= 7'd63) ngap = sel ? 6'd9 : 6'd27;
    else if (rbs >= 7'd64 && rbs <= 7'd79) ngap = sel ? 6'd16 : 6'd32;
    else if (rbs >= 7'd80 && rbs <= 7'd110) ngap = sel ? 6'd16 : 6'd48;

    rest = rbs - {1'b0, ngap};
    m = ({1'b0, ngap} < rest) ? {1'b0, ngap} : rest;

    // gap 1: 2*min(gap, rest); gap 2: bandwidth rounded down to a multiple of twice the gap
    if (!sel) ndl = {m[5:0], 1'b0};
    else if (ngap == 6'd16) ndl = (rbs >= 7'd96) ? 7'd96 : 7'd64;
    else ndl = (rbs >= 7'd54) ? 7'd54 : 7'd36;

    ntil = sel ? {ngap, 1'b0} : ndl;

    // group size from the type-0 allocation table
    if (rbs <= 7'd10) p = 3'd1;
    else if (rbs <= 7'd26) p = 3'd2;
    else if (rbs <= 7'd63) p = 3'd3;
    else p = 3'd4;

    // rows: ceil(ntil / 4p) * p
    unique case (p)
      3'd1: kq = ({1'b0, ntil} + 8'd3) >> 2;
      3'd2: kq = (({1'b0, ntil} + 8'd7) >> 3) << 1;
      3'd3: begin
        if (ntil <= 7'd12) kq = 8'd3;
        else if (ntil <= 7'd24) kq = 8'd6;
        else if (ntil <= 7'd36) kq = 8'd9;
        else if (ntil <= 7'd48) kq = 8'd12;
        else if (ntil <= 7'd60) kq = 8'd15;
        else kq = 8'd18;
      end
      default: kq = (({1'b0, ntil} + 8'd15) >> 4) << 2;
    endcase

    r.rbs     = rbs;
    r.mode    = mode;
    r.gap_err = (ngap == 6'd0);
    r.ngap    = ngap;
    r.ndl     = ndl;
    r.ntil    = ntil;
    r.half    = ntil[6:1];
    r.nrow    = kq[4:0];
    r.nnull   = 5'({kq[4:0], 2'b00} - ntil);
    r.divisor = mode ? rbs : ntil;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/vtp_if.sv @@
// handshake channels for the vrb to prb mapper: request and result
`default_nettype none

interface vtp_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] start_index;
  logic [6:0] block_offset;
  logic [4:0] slot_number;
  logic       last_in;

  modport source (output valid, start_index, block_offset, slot_number, last_in,
                  input ready);
  modport sink (input valid, start_index, block_offset, slot_number, last_in,
                output ready);
endinterface

interface vtp_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] prb_index;
  logic [1:0] status;
  logic       last_out;

  modport source (output valid, prb_index, status, last_out, input ready);
  modport sink (input valid, prb_index, status, last_out, output ready);
endinterface

`default_nettype wire

@@ rtl/vtp_cfg.sv @@
// configuration registers and the mapping parameters derived from them
`default_nettype none

module vtp_cfg
  import vtp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  we_i,
  input  wire logic [CFG_IDX_W-1:0]  idx_i,
  input  wire logic [CFG_DATA_W-1:0] wdata_i,
  output vtp_drv_t                   drv_o
);

  logic [6:0] rbs_q, rbs_d;
  logic       gap_q, gap_d;
  logic       mode_q, mode_d;
  vtp_drv_t   drv_q, drv_d;

  always_comb begin
    rbs_d  = rbs_q;
    gap_d  = gap_q;
    mode_d = mode_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_BANDWIDTH: rbs_d  = wdata_i;
        CFG_GAP_SEL:   gap_d  = wdata_i[0];
        CFG_MODE:      mode_d = wdata_i[0];
        default: ;
      endcase
    end
    // derived set follows the write in the same cycle
    drv_d = vtp_derive(rbs_d, gap_d, mode_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbs_q  <= BANDWIDTH_RESET;
      gap_q  <= 1'b0;
      mode_q <= 1'b0;
      drv_q  <= vtp_derive(BANDWIDTH_RESET, 1'b0, 1'b0);
    end else begin
      rbs_q  <= rbs_d;
      gap_q  <= gap_d;
      mode_q <= mode_d;
      drv_q  <= drv_d;
    end
  end

  assign drv_o = drv_q;

endmodule

`default_nettype wire

@@ rtl/vtp_div_stage.sv @@
// one pipeline stage of the remainder unit: two restoring subtract steps
`default_nettype none

module vtp_div_stage
  import vtp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire vtp_item_t in_item_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output vtp_item_t      out_item_o,
  input  wire logic      out_ready_i
);

  logic      valid_q;
  vtp_item_t item_q, item_d;

  always_comb begin
    item_d = in_item_i;
    if ({6'd0, item_d.rem} >= item_d.dsh) item_d.rem = item_d.rem - item_d.dsh[7:0];
    item_d.dsh = item_d.dsh >> 1;
    if ({6'd0, item_d.rem} >= item_d.dsh) item_d.rem = item_d.rem - item_d.dsh[7:0];
    item_d.dsh = item_d.dsh >> 1;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/lte_vrb_to_prb_mapper_unit.sv @@
// top level of the lte downlink virtual to physical resource block mapper
`default_nettype none

// Maps one virtual resource block (start_index + block_offset) to its physical
// block per the distributed interleaver with odd-slot shift, or modulo the
// bandwidth in localized mode. A new beat is taken every cycle unless stalled;
// results pass an input register, four stages of the restoring remainder
// unit (two quotient bits each, eight in all), the interleaver stage and the
// output register. Backpressure on the result side stalls only the stages
// that are full. Configuration writes take effect at the next edge; the user
// makes them while no beat is in flight, which the block does not enforce.
// Register 0 is bandwidth, 1 gap choice, 2 mode (0 distributed, 1 localized).
module lte_vrb_to_prb_mapper_unit
  import vtp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  vtp_in_if.sink                     req_i,
  vtp_out_if.source                  rsp_o
);

  typedef struct packed {
    logic [6:0] loc;
    logic [7:0] base;
    logic       odd;
    logic       last;
    logic [1:0] status;
  } vtp_perm_t;

  typedef struct packed {
    logic [8:0] prb;
    logic [1:0] status;
    logic       last;
  } vtp_res_t;

  vtp_drv_t drv;

  vtp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .drv_o   (drv)
  );

  // input stage: sum, range checks, divisor alignment
  logic      s0_v_q;
  logic      s0_rdy;
  vtp_item_t s0_q, s0_d;

  logic      div_v   [DIV_STAGES+1];
  logic      div_rdy [DIV_STAGES+1];
  vtp_item_t div_item[DIV_STAGES+1];

  logic      s5_v_q, s5_rdy;
  vtp_perm_t s5_q, s5_d;
  logic      s6_v_q, s6_rdy;
  vtp_res_t  s6_q, s6_d;

  always_comb begin
    s0_d.nvrb = {1'b0, req_i.start_index} + {1'b0, req_i.block_offset};
    s0_d.rem  = s0_d.nvrb;
    s0_d.dsh  = {drv.divisor, 7'd0};
    s0_d.odd  = req_i.slot_number[0];
    s0_d.last = req_i.last_in;
    if (drv.mode) begin
      s0_d.status = (req_i.start_index >= drv.rbs) ? ST_START : ST_OK;
    end else if (drv.gap_err) begin
      s0_d.status = ST_GAP;
    end else begin
      s0_d.status = (req_i.start_index >= drv.ndl) ? ST_START : ST_OK;
    end
  end

  assign s0_rdy      = !s0_v_q || div_rdy[0];
  assign req_i.ready = s0_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_rdy && req_i.valid) begin
      s0_q <= s0_d;
    end
  end

  // remainder unit
  assign div_v[0]    = s0_v_q;
  assign div_item[0] = s0_q;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    vtp_div_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_v[g]),
      .in_item_i   (div_item[g]),
      .in_ready_o  (div_rdy[g]),
      .out_valid_o (div_v[g+1]),
      .out_item_o  (div_item[g+1]),
      .out_ready_i (div_rdy[g+1])
    );
  end

  assign div_rdy[DIV_STAGES] = s5_rdy;

  // interleaver stage: position within the period
  vtp_item_t  dq;
  logic [6:0] vt;
  logic [7:0] lp1, lp2, lsel, nrow8, nhalf8;
  logic       has_null, tail;

  always_comb begin
    dq       = div_item[DIV_STAGES];
    vt       = dq.rem[6:0];
    nrow8    = {3'b0, drv.nrow};
    nhalf8   = {4'b0, drv.nnull[4:1]};
    lp1      = (vt[0] ? {2'b0, drv.nrow, 1'b0} : 8'd0) + {2'b0, vt[6:1]};
    lp2      = ({3'b0, drv.nrow} * {6'b0, vt[1:0]}) + {3'b0, vt[6:2]};
    has_null = (drv.nnull != 5'd0);
    tail     = ({1'b0, vt} + {3'b0, drv.nnull}) >= {1'b0, drv.ntil};
    priority if (has_null && tail && vt[0]) lsel = lp1 - nrow8;
    else if (has_null && tail) lsel = lp1 - nrow8 + nhalf8;
    else if (has_null && vt[1]) lsel = lp2 - nhalf8;
    else lsel = lp2;

    s5_d.loc    = drv.mode ? vt : lsel[6:0];
    s5_d.base   = dq.nvrb - dq.rem;
    s5_d.odd    = dq.odd;
    s5_d.last   = dq.last;
    s5_d.status = dq.status;
  end

  assign s5_rdy = !s5_v_q || s6_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (s5_rdy) begin
      s5_v_q <= div_v[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_rdy && div_v[DIV_STAGES]) begin
      s5_q <= s5_d;
    end
  end

  // output stage: odd-slot half shift and gap insertion
  logic [7:0] wrap;
  logic [6:0] l2;
  logic [9:0] t, t_gap;

  always_comb begin
    wrap = {1'b0, s5_q.loc} + {2'b0, drv.half};
    if (wrap >= {1'b0, drv.ntil}) wrap = wrap - {1'b0, drv.ntil};
    l2    = s5_q.odd ? wrap[6:0] : s5_q.loc;
    t     = {3'b0, l2} + {2'b0, s5_q.base};
    t_gap = t + {4'b0, drv.ngap} - {4'b0, drv.half};

    if (s5_q.status != ST_OK) s6_d.prb = 9'd0;
    else if (drv.mode) s6_d.prb = {2'b0, s5_q.loc};
    else if (t < {4'b0, drv.half}) s6_d.prb = t[8:0];
    else s6_d.prb = t_gap[8:0];
    s6_d.status = s5_q.status;
    s6_d.last   = s5_q.last;
  end

  assign s6_rdy = !s6_v_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (s6_rdy) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s6_rdy && s5_v_q) begin
      s6_q <= s6_d;
    end
  end

  assign rsp_o.valid     = s6_v_q;
  assign rsp_o.prb_index = s6_q.prb;
  assign rsp_o.status    = s6_q.status;
  assign rsp_o.last_out  = s6_q.last;

`ifndef SYNTHESIS
  a_err_zero_prb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_OK |-> rsp_o.prb_index == 9'd0)
    else $error("nonzero prb index on a flagged result");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v[DIV_STAGES] |-> div_item[DIV_STAGES].rem <= div_item[DIV_STAGES].nvrb)
    else $error("remainder above its dividend");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> s0_v_q)
    else $error("accepted beat missing from the input stage");
`endif

endmodule

`default_nettype wire
